// ===== rtl/tfn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants and types for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  // result magnitude is 0..32767: fifteen root bits
  localparam int ROOT_BITS  = 15;
  localparam int OUT_BITS   = 16;
  // 32767 = 2^15 - 1, so a multiply by it is a shift and a subtract
  localparam int SCALE_SHIFT = 15;

  // per-triangle control that rides along the root stages
  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } step_ctl_t;

endpackage

// ===== rtl/tfn_root_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_root_step
// One bit of the scaled square root for all three components.
// Keeps rem = T - r^2*s and p = r*s; trying bit b costs
// (p << (b+1)) + (s << 2b).
// ----------------------------------------------------------------------------
module tfn_root_step #(
  parameter int BIT = 14,
  parameter int SW  = 36,
  parameter int WW  = 70
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  tfn_pkg::step_ctl_t                    ctl_i,
  input  logic [SW-1:0]                         s_i,
  input  logic [2:0][tfn_pkg::ROOT_BITS-1:0]    r_i,
  input  logic [2:0][WW-1:0]                    p_i,
  input  logic [2:0][WW-1:0]                    rem_i,
  output tfn_pkg::step_ctl_t                    ctl_o,
  output logic [SW-1:0]                         s_o,
  output logic [2:0][tfn_pkg::ROOT_BITS-1:0]    r_o,
  output logic [2:0][WW-1:0]                    p_o,
  output logic [2:0][WW-1:0]                    rem_o
);
  import tfn_pkg::*;

  logic [2:0][WW-1:0]        delta;
  logic [2:0][ROOT_BITS-1:0] r_nxt;
  logic [2:0][WW-1:0]        p_nxt;
  logic [2:0][WW-1:0]        rem_nxt;
  logic [WW-1:0]             s_wide;

  assign s_wide = WW'(s_i);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      delta[l] = (p_i[l] << (BIT + 1)) + (s_wide << (2 * BIT));
      if (rem_i[l] >= delta[l]) begin
        r_nxt[l]   = r_i[l] | (ROOT_BITS'(1) << BIT);
        p_nxt[l]   = p_i[l] + (s_wide << BIT);
        rem_nxt[l] = rem_i[l] - delta[l];
      end else begin
        r_nxt[l]   = r_i[l];
        p_nxt[l]   = p_i[l];
        rem_nxt[l] = rem_i[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o <= ctl_i;
      s_o   <= s_i;
      r_o   <= r_nxt;
      p_o   <= p_nxt;
      rem_o <= rem_nxt;
    end
  end

endmodule

// ===== rtl/triangle_face_normal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal n = (C-B) x (A-B), scaled by 32767 and truncated.
// ----------------------------------------------------------------------------
// Fully pipelined: one triangle per clock unless the output stalls. Eight
// stages form the cross product, the squared length s and the target
// 32767^2*c^2 exactly; fifteen stages then resolve one result bit each for
// all three components, and one output register drives the result.
// Each stage holds its request until the next takes it, so a stall on the
// output fills bubbles first and then backs up to in_tready. A zero-length
// cross product returns zeros with the degenerate flag in out_tuser.
module triangle_face_normal #(
  parameter int COORD_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero pad
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]          in_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // normal_x, normal_y, normal_z
  output logic [3*tfn_pkg::OUT_BITS-1:0]              out_tdata,
  // degenerate
  output logic                                        out_tuser
);
  import tfn_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int D  = CB + 1;             // vertex difference
  localparam int PW = 2 * D;              // cross product term
  localparam int NW = PW + 1;             // cross product component
  localparam int MW = PW;                 // its magnitude
  localparam int LB = (MW + 1) / 2;       // low half for squaring
  localparam int HB = MW - LB;
  localparam int QW = 2 * MW;             // component squared
  localparam int SW = QW + 2;             // squared length
  localparam int T1W = QW + SCALE_SHIFT;
  localparam int WW = SW + 32;            // root working width
  localparam int FRONT = 8;
  localparam int NST = FRONT + ROOT_BITS + 1;

  // ---------------- stage handshake ----------------
  logic [NST-1:0] vld_r;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = out_tready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // ---------------- stage 1: edge vectors ----------------
  logic [CB-1:0] va [3];
  logic [CB-1:0] vb [3];
  logic [CB-1:0] vc [3];
  logic [D-1:0]  du_nxt [3];
  logic [D-1:0]  dv_nxt [3];
  logic [D-1:0]  du_r [3];
  logic [D-1:0]  dv_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      va[k] = in_tdata[k*CB +: CB];
      vb[k] = in_tdata[(k+3)*CB +: CB];
      vc[k] = in_tdata[(k+6)*CB +: CB];
      du_nxt[k] = D'($signed(vc[k])) - D'($signed(vb[k]));
      dv_nxt[k] = D'($signed(va[k])) - D'($signed(vb[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      du_r <= du_nxt;
      dv_r <= dv_nxt;
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [PW-1:0] prod_nxt [6];
  logic [PW-1:0]        prod_r [6];

  always_comb begin
    prod_nxt[0] = $signed(du_r[1]) * $signed(dv_r[2]);
    prod_nxt[1] = $signed(du_r[2]) * $signed(dv_r[1]);
    prod_nxt[2] = $signed(du_r[2]) * $signed(dv_r[0]);
    prod_nxt[3] = $signed(du_r[0]) * $signed(dv_r[2]);
    prod_nxt[4] = $signed(du_r[0]) * $signed(dv_r[1]);
    prod_nxt[5] = $signed(du_r[1]) * $signed(dv_r[0]);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int k = 0; k < 6; k++) prod_r[k] <= prod_nxt[k];
    end
  end

  // ---------------- stage 3: cross product ----------------
  logic [NW-1:0] n_nxt [3];
  logic [NW-1:0] n_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_nxt[k] = NW'($signed(prod_r[2*k])) - NW'($signed(prod_r[2*k+1]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) n_r <= n_nxt;
  end

  // ---------------- stage 4: magnitude and sign ----------------
  logic [NW-1:0] abs_n [3];
  logic [MW-1:0] mag_r [3];
  logic [2:0]    neg4_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs_n[k] = n_r[k][NW-1] ? (NW'(0) - n_r[k]) : n_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int k = 0; k < 3; k++) begin
        mag_r[k]  <= abs_n[k][MW-1:0];
        neg4_r[k] <= n_r[k][NW-1];
      end
    end
  end

  // ---------------- stage 5: partial squares ----------------
  logic [2*HB-1:0]    hh_r [3];
  logic [HB+LB-1:0]   hl_r [3];
  logic [2*LB-1:0]    ll_r [3];
  logic [2:0]         neg5_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int k = 0; k < 3; k++) begin
        hh_r[k] <= (2*HB)'(mag_r[k][MW-1:LB]) * (2*HB)'(mag_r[k][MW-1:LB]);
        hl_r[k] <= (HB+LB)'(mag_r[k][MW-1:LB]) * (HB+LB)'(mag_r[k][LB-1:0]);
        ll_r[k] <= (2*LB)'(mag_r[k][LB-1:0]) * (2*LB)'(mag_r[k][LB-1:0]);
      end
      neg5_r <= neg4_r;
    end
  end

  // ---------------- stage 6: component squares ----------------
  logic [QW-1:0] csq_r [3];
  logic [2:0]    neg6_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int k = 0; k < 3; k++) begin
        csq_r[k] <= (QW'(hh_r[k]) << (2 * LB)) + (QW'(hl_r[k]) << (LB + 1))
                    + QW'(ll_r[k]);
      end
      neg6_r <= neg5_r;
    end
  end

  // ---------------- stage 7: length and first scale ----------------
  logic [SW-1:0]  s7_r;
  logic [T1W-1:0] t1_r [3];
  logic [2:0]     neg7_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s7_r <= SW'(csq_r[0]) + SW'(csq_r[1]) + SW'(csq_r[2]);
      for (int k = 0; k < 3; k++) begin
        t1_r[k] <= (T1W'(csq_r[k]) << SCALE_SHIFT) - T1W'(csq_r[k]);
      end
      neg7_r <= neg6_r;
    end
  end

  // ---------------- stage 8: second scale ----------------
  logic [SW-1:0]      s8_r;
  logic [2:0][WW-1:0] t8_r;
  step_ctl_t          ctl8_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s8_r <= s7_r;
      for (int k = 0; k < 3; k++) begin
        t8_r[k] <= (WW'(t1_r[k]) << SCALE_SHIFT) - WW'(t1_r[k]);
      end
      ctl8_r.degen <= (s7_r == '0);
      ctl8_r.neg   <= neg7_r;
    end
  end

  // ---------------- root stages, bit 14 down to bit 0 ----------------
  step_ctl_t                 ctl_c [ROOT_BITS+1];
  logic [SW-1:0]             s_c   [ROOT_BITS+1];
  logic [2:0][ROOT_BITS-1:0] r_c   [ROOT_BITS+1];
  logic [2:0][WW-1:0]        p_c   [ROOT_BITS+1];
  logic [2:0][WW-1:0]        rem_c [ROOT_BITS+1];

  assign ctl_c[0] = ctl8_r;
  assign s_c[0]   = s8_r;
  assign r_c[0]   = '0;
  assign p_c[0]   = '0;
  assign rem_c[0] = t8_r;

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_root
    tfn_root_step #(
      .BIT (ROOT_BITS - 1 - g),
      .SW  (SW),
      .WW  (WW)
    ) u_step (
      .clk   (clk),
      .en    (rdy[FRONT+g]),
      .ctl_i (ctl_c[g]),
      .s_i   (s_c[g]),
      .r_i   (r_c[g]),
      .p_i   (p_c[g]),
      .rem_i (rem_c[g]),
      .ctl_o (ctl_c[g+1]),
      .s_o   (s_c[g+1]),
      .r_o   (r_c[g+1]),
      .p_o   (p_c[g+1]),
      .rem_o (rem_c[g+1])
    );
  end

  // ---------------- output register ----------------
  step_ctl_t                  ctl_f;
  logic [2:0][ROOT_BITS-1:0]  r_f;
  logic [3*OUT_BITS-1:0]      out_data_nxt;
  logic [3*OUT_BITS-1:0]      out_data_r;
  logic                       out_degen_r;

  assign ctl_f = ctl_c[ROOT_BITS];
  assign r_f   = r_c[ROOT_BITS];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (ctl_f.degen) begin
        out_data_nxt[k*OUT_BITS +: OUT_BITS] = '0;
      end else if (ctl_f.neg[k]) begin
        out_data_nxt[k*OUT_BITS +: OUT_BITS] = OUT_BITS'(0) - OUT_BITS'(r_f[k]);
      end else begin
        out_data_nxt[k*OUT_BITS +: OUT_BITS] = OUT_BITS'(r_f[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      out_data_r  <= out_data_nxt;
      out_degen_r <= ctl_f.degen;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_degen_r;

  // ---------------- checks ----------------
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result with nonzero normal");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_BITS-1:0] != {1'b1, {(OUT_BITS-1){1'b0}}} &&
                   out_tdata[2*OUT_BITS-1:OUT_BITS] != {1'b1, {(OUT_BITS-1){1'b0}}} &&
                   out_tdata[3*OUT_BITS-1:2*OUT_BITS] != {1'b1, {(OUT_BITS-1){1'b0}}})
    else $error("normal component out of range");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted request lost at first stage");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata != '0)
    else $error("nondegenerate result with zero normal");

endmodule
